[rtl/core/pipp_pkg.sv]
// Shared types and constants for the point-in-polygon parity core.
package pipp_pkg;

	// Width of every coordinate port, whatever part of it is used.
	localparam int unsigned FIELD_W = 32;

	// Vertex count saturates here; fewer than this many vertices is no polygon.
	localparam logic [1:0] MIN_VERTICES = 2'd3;

	// Per-request control that travels down the pipeline with the edge data.
	typedef struct packed {
		logic first;    // request opened a new polygon
		logic last;     // request closes the polygon and yields a result
		logic few;      // fewer than three vertices seen, this one included
	} pipp_flags_t;

endpackage

[rtl/core/pipp_front.sv]
// Polygon state (query point, first and previous vertex, count) and stage 1 register.
module pipp_front import pipp_pkg::*; #(
	parameter int unsigned CW = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic [FIELD_W-1:0]    query_x,
	input  logic [FIELD_W-1:0]    query_y,
	input  logic [FIELD_W-1:0]    vertex_x,
	input  logic [FIELD_W-1:0]    vertex_y,
	input  logic                  first_vertex,
	input  logic                  last_vertex,
	output logic signed [CW-1:0]  px_s1,
	output logic signed [CW-1:0]  py_s1,
	output logic signed [CW-1:0]  vx_s1,
	output logic signed [CW-1:0]  vy_s1,
	output logic signed [CW-1:0]  prev_x_s1,
	output logic signed [CW-1:0]  prev_y_s1,
	output logic signed [CW-1:0]  start_x_s1,
	output logic signed [CW-1:0]  start_y_s1,
	output pipp_flags_t           flags_s1
);

	logic signed [CW-1:0] point_x_q, point_y_q;
	logic signed [CW-1:0] start_x_q, start_y_q;
	logic signed [CW-1:0] prior_x_q, prior_y_q;
	logic [1:0]           count_q;

	logic signed [CW-1:0] qx, qy, vx, vy;
	logic signed [CW-1:0] pt_x_nxt, pt_y_nxt, st_x_nxt, st_y_nxt;
	logic [1:0]           count_nxt;

	// Only the low CW bits of each coordinate carry meaning.
	assign qx = $signed(query_x[CW-1:0]);
	assign qy = $signed(query_y[CW-1:0]);
	assign vx = $signed(vertex_x[CW-1:0]);
	assign vy = $signed(vertex_y[CW-1:0]);

	always_comb begin
		pt_x_nxt = first_vertex ? qx : point_x_q;
		pt_y_nxt = first_vertex ? qy : point_y_q;
		st_x_nxt = first_vertex ? vx : start_x_q;
		st_y_nxt = first_vertex ? vy : start_y_q;
		if (first_vertex) begin
			count_nxt = 2'd1;
		end else if (count_q == MIN_VERTICES) begin
			count_nxt = count_q;
		end else begin
			count_nxt = count_q + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_x_q <= '0;
			point_y_q <= '0;
			start_x_q <= '0;
			start_y_q <= '0;
			prior_x_q <= '0;
			prior_y_q <= '0;
			count_q   <= '0;
		end else if (load) begin
			point_x_q <= pt_x_nxt;
			point_y_q <= pt_y_nxt;
			start_x_q <= st_x_nxt;
			start_y_q <= st_y_nxt;
			prior_x_q <= vx;
			prior_y_q <= vy;
			count_q   <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			px_s1          <= pt_x_nxt;
			py_s1          <= pt_y_nxt;
			vx_s1          <= vx;
			vy_s1          <= vy;
			prev_x_s1      <= prior_x_q;
			prev_y_s1      <= prior_y_q;
			start_x_s1     <= st_x_nxt;
			start_y_s1     <= st_y_nxt;
			flags_s1.first <= first_vertex;
			flags_s1.last  <= last_vertex;
			flags_s1.few   <= (count_nxt < MIN_VERTICES);
		end
	end

endmodule

[rtl/core/pipp_edge.sv]
// One edge against the query point: straddle test and the two cross products, registered.
module pipp_edge #(
	parameter int unsigned CW = 32
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [CW-1:0]       px,
	input  logic signed [CW-1:0]       py,
	input  logic signed [CW-1:0]       ax,
	input  logic signed [CW-1:0]       ay,
	input  logic signed [CW-1:0]       bx,
	input  logic signed [CW-1:0]       by,
	output logic                       straddle_s2,
	output logic                       dy_neg_s2,
	output logic signed [2*CW+1:0]     lhs_s2,
	output logic signed [2*CW+1:0]     rhs_s2
);

	logic signed [CW:0]     dy, dpx, dbx, dpy;
	logic signed [2*CW+1:0] lhs, rhs;
	logic                   straddle;

	assign dy  = {by[CW-1], by} - {ay[CW-1], ay};
	assign dpx = {px[CW-1], px} - {ax[CW-1], ax};
	assign dbx = {bx[CW-1], bx} - {ax[CW-1], ax};
	assign dpy = {py[CW-1], py} - {ay[CW-1], ay};

	// The crossing lies right of the point when (px-ax)*dy and (bx-ax)*(py-ay)
	// order against each other as the sign of dy says; no division needed.
	assign lhs = dpx * dy;
	assign rhs = dbx * dpy;

	// Exactly one endpoint strictly above the point's horizontal line.
	assign straddle = (ay > py) != (by > py);

	always_ff @(posedge clk) begin
		if (en) begin
			straddle_s2 <= straddle;
			dy_neg_s2   <= dy[CW];
			lhs_s2      <= lhs;
			rhs_s2      <= rhs;
		end
	end

endmodule

[rtl/core/pipp_back.sv]
// Crossing decisions, running parity and the result register.
module pipp_back import pipp_pkg::*; #(
	parameter int unsigned CW = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  pipp_flags_t                flags_s2,
	input  logic                       e_straddle,
	input  logic                       e_dy_neg,
	input  logic signed [2*CW+1:0]     e_lhs,
	input  logic signed [2*CW+1:0]     e_rhs,
	input  logic                       c_straddle,
	input  logic                       c_dy_neg,
	input  logic signed [2*CW+1:0]     c_lhs,
	input  logic signed [2*CW+1:0]     c_rhs,
	output logic                       inside_res,
	output logic                       too_few_vertices
);

	logic parity_q;
	logic e_cross, c_cross, parity_nxt, closed;

	// A crossing exactly at the point is not strictly right of it, so no toggle.
	assign e_cross = e_straddle && (e_lhs != e_rhs) && ((e_lhs < e_rhs) != e_dy_neg);
	assign c_cross = c_straddle && (c_lhs != c_rhs) && ((c_lhs < c_rhs) != c_dy_neg);

	assign parity_nxt = flags_s2.first ? 1'b0 : (parity_q ^ e_cross);
	assign closed     = parity_nxt ^ c_cross;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
		end else if (en) begin
			parity_q <= parity_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (en && flags_s2.last) begin
			inside_res       <= closed && !flags_s2.few;
			too_few_vertices <= flags_s2.few;
		end
	end

endmodule

[rtl/core/point_in_polygon_parity_core.sv]
// Even-odd point-in-polygon test over a stream of polygon vertices.
//
// Input channel (in_valid / in_stall): one vertex per request. first_vertex
// opens a polygon and latches query_x / query_y; last_vertex closes it. Only
// the low COORD_BITS bits of each coordinate are used, as a signed value.
// Output channel (out_valid / out_stall): one result per request that has
// last_vertex set, carrying inside_res and too_few_vertices; other requests
// give no result.
// Throughput is one request per cycle while the receiver does not stall. A result
// passes through a register behind the vertex state, a register behind the four
// cross-product multipliers, then the result register.
// When the receiver stalls, the result register holds; requests that give no
// result keep flowing and the input stalls only once the pipeline is full.
// Reset clears the query point, first and previous vertex, vertex count and
// parity to zero and empties the pipeline.
module point_in_polygon_parity_core import pipp_pkg::*; #(
	parameter int unsigned COORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [FIELD_W-1:0]   query_x,
	input  logic [FIELD_W-1:0]   query_y,
	input  logic [FIELD_W-1:0]   vertex_x,
	input  logic [FIELD_W-1:0]   vertex_y,
	input  logic                 first_vertex,
	input  logic                 last_vertex,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 inside_res,
	output logic                 too_few_vertices
);

	localparam int unsigned CW = COORD_BITS;

	logic signed [CW-1:0] px_s1, py_s1, vx_s1, vy_s1;
	logic signed [CW-1:0] prev_x_s1, prev_y_s1, start_x_s1, start_y_s1;
	pipp_flags_t          flags_s1, flags_s2;

	logic                   e_straddle_s2, e_dy_neg_s2, c_straddle_s2, c_dy_neg_s2;
	logic signed [2*CW+1:0] e_lhs_s2, e_rhs_s2, c_lhs_s2, c_rhs_s2;

	logic valid_s1, valid_s2, out_valid_q;
	logic in_acc, adv_s1, adv_s2, out_free;

	// Requests without a result pass stage 2 even while a result waits.
	assign out_free = !out_valid_q || !out_stall;
	assign adv_s2   = valid_s2 && (!flags_s2.last || out_free);
	assign adv_s1   = valid_s1 && (!valid_s2 || adv_s2);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s2 && flags_s2.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			flags_s2 <= flags_s1;
		end
	end

	assign out_valid = out_valid_q;

	pipp_front #(.CW(CW)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (in_acc),
		.query_x      (query_x),
		.query_y      (query_y),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.first_vertex (first_vertex),
		.last_vertex  (last_vertex),
		.px_s1        (px_s1),
		.py_s1        (py_s1),
		.vx_s1        (vx_s1),
		.vy_s1        (vy_s1),
		.prev_x_s1    (prev_x_s1),
		.prev_y_s1    (prev_y_s1),
		.start_x_s1   (start_x_s1),
		.start_y_s1   (start_y_s1),
		.flags_s1     (flags_s1)
	);

	// Edge from this vertex to the previous one.
	pipp_edge #(.CW(CW)) u_edge (
		.clk         (clk),
		.en          (adv_s1),
		.px          (px_s1),
		.py          (py_s1),
		.ax          (vx_s1),
		.ay          (vy_s1),
		.bx          (prev_x_s1),
		.by          (prev_y_s1),
		.straddle_s2 (e_straddle_s2),
		.dy_neg_s2   (e_dy_neg_s2),
		.lhs_s2      (e_lhs_s2),
		.rhs_s2      (e_rhs_s2)
	);

	// Closing edge from the first vertex to this one.
	pipp_edge #(.CW(CW)) u_close (
		.clk         (clk),
		.en          (adv_s1),
		.px          (px_s1),
		.py          (py_s1),
		.ax          (start_x_s1),
		.ay          (start_y_s1),
		.bx          (vx_s1),
		.by          (vy_s1),
		.straddle_s2 (c_straddle_s2),
		.dy_neg_s2   (c_dy_neg_s2),
		.lhs_s2      (c_lhs_s2),
		.rhs_s2      (c_rhs_s2)
	);

	pipp_back #(.CW(CW)) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (adv_s2),
		.flags_s2         (flags_s2),
		.e_straddle       (e_straddle_s2),
		.e_dy_neg         (e_dy_neg_s2),
		.e_lhs            (e_lhs_s2),
		.e_rhs            (e_rhs_s2),
		.c_straddle       (c_straddle_s2),
		.c_dy_neg         (c_dy_neg_s2),
		.c_lhs            (c_lhs_s2),
		.c_rhs            (c_rhs_s2),
		.inside_res       (inside_res),
		.too_few_vertices (too_few_vertices)
	);

endmodule

[tb/tb_point_in_polygon_parity_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the point-in-polygon parity core: directed polygons, random streams.
module tb_point_in_polygon_parity_core;

	localparam int unsigned COORD_BITS = 32;
	localparam int unsigned FW = pipp_pkg::FIELD_W;
	localparam int ITEMS = 1700;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [FW-1:0] MAXC = 32'h7fff_ffff;
	localparam logic [FW-1:0] MINC = 32'h8000_0000;

	typedef struct {
		logic [FW-1:0] qx;
		logic [FW-1:0] qy;
		logic [FW-1:0] vx;
		logic [FW-1:0] vy;
		logic opens;
		logic closes;
		logic drain;
	} vertex_req_t;

	typedef struct {
		logic inner;
		logic few;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [FW-1:0] query_x = '0;
	logic [FW-1:0] query_y = '0;
	logic [FW-1:0] vertex_x = '0;
	logic [FW-1:0] vertex_y = '0;
	logic first_vertex = 1'b0;
	logic last_vertex = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic inside_res;
	logic too_few_vertices;

	vertex_req_t reqs[$];
	vertex_req_t cur_req;
	verdict_t verdicts_due[$];
	verdict_t want;

	// Shadow of the block's polygon state.
	longint pt_x = 0, pt_y = 0, org_x = 0, org_y = 0, prev_x = 0, prev_y = 0;
	logic odd = 1'b0;
	int unsigned vcount = 0;

	int taken = 0, total_reqs = 0, results_seen = 0, mismatches = 0;
	int inside_seen = 0, few_seen = 0, cycles = 0;
	int tx_gap = 0, rx_gap = 0, hold_left = 0;
	logic hold_done = 1'b0;
	logic go;

	point_in_polygon_parity_core #(.COORD_BITS(COORD_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.query_x(query_x),
		.query_y(query_y),
		.vertex_x(vertex_x),
		.vertex_y(vertex_y),
		.first_vertex(first_vertex),
		.last_vertex(last_vertex),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.inside_res(inside_res),
		.too_few_vertices(too_few_vertices)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint to_coord(logic [FW-1:0] raw);
		longint t;
		t = raw;
		t = t <<< (64 - COORD_BITS);
		return t >>> (64 - COORD_BITS);
	endfunction

	// Does the rightward ray from the held point cross edge a-b strictly right of it?
	function automatic logic ray_hits(longint ax, longint ay, longint bx, longint by);
		logic signed [67:0] t0, t1, t2, t3, lhs, rhs;
		longint dy;
		if ((ay > pt_y) == (by > pt_y))
			return 1'b0;
		dy = by - ay;
		t0 = pt_x - ax;
		t1 = dy;
		t2 = bx - ax;
		t3 = pt_y - ay;
		lhs = t0 * t1;
		rhs = t2 * t3;
		if (lhs == rhs)
			return 1'b0;
		return (lhs < rhs) != (dy < 0);
	endfunction

	task automatic track_vertex(vertex_req_t r);
		longint vx, vy;
		logic closed;
		verdict_t v;
		vx = to_coord(r.vx);
		vy = to_coord(r.vy);
		if (r.opens) begin
			pt_x = to_coord(r.qx);
			pt_y = to_coord(r.qy);
			org_x = vx;
			org_y = vy;
			odd = 1'b0;
			vcount = 1;
		end else begin
			if (ray_hits(vx, vy, prev_x, prev_y))
				odd = ~odd;
			if (vcount < pipp_pkg::MIN_VERTICES)
				vcount++;
		end
		prev_x = vx;
		prev_y = vy;
		if (r.closes) begin
			closed = odd ^ ray_hits(org_x, org_y, vx, vy);
			v.few = (vcount < pipp_pkg::MIN_VERTICES);
			v.inner = v.few ? 1'b0 : closed;
			verdicts_due = {verdicts_due, v};
		end
	endtask

	task automatic add_req(logic [FW-1:0] qx, logic [FW-1:0] qy, logic [FW-1:0] vx,
			logic [FW-1:0] vy, logic opens, logic closes);
		vertex_req_t r;
		r.qx = qx;
		r.qy = qy;
		r.vx = vx;
		r.vy = vy;
		r.opens = opens;
		r.closes = closes;
		r.drain = 1'b0;
		reqs = {reqs, r};
	endtask

	function automatic logic [FW-1:0] pick_coord(int mode, logic [FW-1:0] centre);
		case (mode)
			0: return centre + $urandom_range(0, 80) - 32'd40;
			1: return $urandom();
			2: begin
				case ($urandom_range(0, 5))
					0: return MAXC;
					1: return MINC;
					2: return '0;
					3: return '1;
					4: return $urandom();
					default: return centre;
				endcase
			end
			default: return centre + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
		endcase
	endfunction

	function automatic logic idling_allowed();
		return (taken + 250 < total_reqs) && ((taken / 200) % 3 != 2);
	endfunction

	task automatic flag_mismatch(string field, logic exp_v, logic act_v);
		mismatches++;
		if (mismatches <= 10)
			$display("result %0d: %s expected %b, got %b", results_seen, field, exp_v, act_v);
	endtask

	// Sender: offers the queued requests, with bursts of idle cycles.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				track_vertex(cur_req);
				taken++;
			end
			if (!in_valid || !in_stall) begin
				go = 1'b0;
				if (tx_gap > 0)
					tx_gap--;
				else if (reqs.size() != 0 && !(reqs[0].drain && verdicts_due.size() != 0)) begin
					go = 1'b1;
					cur_req = reqs.pop_front();
					if (idling_allowed() && $urandom_range(0, 7) == 0)
						tx_gap = $urandom_range(1, 6);
				end
				in_valid <= go;
				if (go) begin
					query_x <= cur_req.qx;
					query_y <= cur_req.qy;
					vertex_x <= cur_req.vx;
					vertex_y <= cur_req.vy;
					first_vertex <= cur_req.opens;
					last_vertex <= cur_req.closes;
				end
			end
		end
	end

	// One long hold-off on the result side, so that the pipeline fills and stalls its input.
	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
		else if (!hold_done && results_seen >= 60) begin
			hold_left <= 100;
			hold_done <= 1'b1;
		end
	end

	// Receiver: checks every result against the oldest outstanding verdict.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (verdicts_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d arrived with no request awaiting one: inside %b few %b",
							results_seen, inside_res, too_few_vertices);
				end else begin
					want = verdicts_due.pop_front();
					if (inside_res !== want.inner)
						flag_mismatch("inside_res", want.inner, inside_res);
					if (too_few_vertices !== want.few)
						flag_mismatch("too_few_vertices", want.few, too_few_vertices);
				end
				results_seen++;
				inside_seen += (inside_res === 1'b1);
				few_seen += (too_few_vertices === 1'b1);
			end
			if (rx_gap > 0)
				rx_gap--;
			else if (idling_allowed() && $urandom_range(0, 9) == 0)
				rx_gap = $urandom_range(1, 6);
			out_stall <= (rx_gap != 0) || (hold_left != 0);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d verdicts still outstanding",
				cycles, verdicts_due.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int n, mode, next_drain;
		logic [FW-1:0] cx, cy;
		vertex_req_t r;

		// No polygon opened since reset: the chain starts from the cleared state.
		add_req(MAXC, MINC, 32'd10, -32'sd10, 1'b0, 1'b0);
		add_req('0, '0, 32'd10, 32'd10, 1'b0, 1'b0);
		add_req('0, '0, -32'sd10, '0, 1'b0, 1'b1);
		// Carries on past a last vertex without a new first one.
		add_req('0, '0, 32'd5, 32'd5, 1'b0, 1'b1);
		// One and two vertices at the coordinate extremes.
		add_req(MAXC, MINC, MINC, MAXC, 1'b1, 1'b1);
		add_req('0, '0, MINC, MINC, 1'b1, 1'b0);
		add_req(MINC, MAXC, MAXC, MAXC, 1'b0, 1'b1);
		// Full-range square around the origin.
		add_req('0, '0, MINC, MINC, 1'b1, 1'b0);
		add_req('0, '0, MAXC, MINC, 1'b0, 1'b0);
		add_req('0, '0, MAXC, MAXC, 1'b0, 1'b0);
		add_req('0, '0, MINC, MAXC, 1'b0, 1'b1);
		// Point lying exactly on a sloping edge.
		add_req(32'd5, '0, '0, -32'sd10, 1'b1, 1'b0);
		add_req('0, '0, 32'd10, 32'd10, 1'b0, 1'b0);
		add_req('0, '0, -32'sd10, 32'd10, 1'b0, 1'b1);
		// A vertex at the point's height.
		add_req('0, '0, 32'd10, '0, 1'b1, 1'b0);
		add_req('0, '0, -32'sd10, 32'd10, 1'b0, 1'b0);
		add_req('0, '0, -32'sd10, -32'sd10, 1'b0, 1'b1);
		// Point on a corner and on a side of the full-range square.
		add_req(MAXC, MAXC, MINC, MINC, 1'b1, 1'b0);
		add_req('0, '0, MAXC, MINC, 1'b0, 1'b0);
		add_req('0, '0, MAXC, MAXC, 1'b0, 1'b0);
		add_req('0, '0, MINC, MAXC, 1'b0, 1'b1);
		add_req(MINC, '0, MINC, MINC, 1'b1, 1'b0);
		add_req('0, '0, MAXC, MINC, 1'b0, 1'b0);
		add_req('0, '0, MAXC, MAXC, 1'b0, 1'b0);
		add_req('0, '0, MINC, MAXC, 1'b0, 1'b1);

		next_drain = 500;
		while (reqs.size() < ITEMS) begin
			if ($urandom_range(0, 19) == 0) begin
				r.qx = $urandom();
				r.qy = $urandom();
				r.vx = $urandom();
				r.vy = $urandom();
				r.opens = $urandom_range(0, 1);
				r.closes = $urandom_range(0, 1);
				r.drain = 1'b0;
				reqs = {reqs, r};
			end else begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
				mode = $urandom_range(0, 3);
				cx = pick_coord((mode == 2) ? 2 : 1, '0);
				cy = pick_coord((mode == 2) ? 2 : 1, '0);
				for (int i = 0; i < n; i++) begin
					r.qx = (i == 0) ? cx : $urandom();
					r.qy = (i == 0) ? cy : $urandom();
					r.vx = pick_coord(mode, cx);
					r.vy = pick_coord(mode, cy);
					r.opens = (i == 0);
					// Now and then the closing flag goes missing and the chain runs on.
					r.closes = (i == n - 1) && ($urandom_range(0, 11) != 0);
					r.drain = (i == 0) && (reqs.size() >= next_drain);
					if (r.drain)
						next_drain += 450;
					reqs = {reqs, r};
				end
			end
		end
		total_reqs = reqs.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (reqs.size() != 0 || in_valid)
			@(negedge clk);
		while (verdicts_due.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("%0d vertex requests taken, %0d polygon results checked", taken, results_seen);
		$display("(%0d inside, %0d too small)", inside_seen, few_seen);
		if (mismatches == 0 && verdicts_due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d verdicts outstanding", mismatches, verdicts_due.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
